### sv/crcfd_pkg.sv
package crcfd_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned CRC_W       = 16;
	localparam int unsigned KIND_W      = 2;
	localparam int unsigned REASON_W    = 3;
	localparam int unsigned NUM_REGS    = 4;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned FIFO_DEPTH  = 4;

	localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
	localparam logic [BYTE_W-1:0] LEN_SAT  = 8'hFF;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;
	localparam logic [BYTE_W-1:0] END_MARKER_RST  = 8'h0D;
	localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST = 8'd255;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_MARKER  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd3;

	localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

	localparam logic [REASON_W-1:0] WHY_NONE   = 3'd0;
	localparam logic [REASON_W-1:0] WHY_LENGTH = 3'd1;
	localparam logic [REASON_W-1:0] WHY_CRC    = 3'd2;
	localparam logic [REASON_W-1:0] WHY_END    = 3'd3;
	localparam logic [REASON_W-1:0] WHY_CMD    = 3'd4;

	typedef enum logic [3:0] {
		PH_SYNC1  = 4'd0,
		PH_SYNC2  = 4'd1,
		PH_LEN_LO = 4'd2,
		PH_LEN_HI = 4'd3,
		PH_CMD    = 4'd4,
		PH_SEQ    = 4'd5,
		PH_DATA   = 4'd6,
		PH_CRC_LO = 4'd7,
		PH_CRC_HI = 4'd8,
		PH_END    = 4'd9
	} phase_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [BYTE_W-1:0]   payload_byte;
		logic                payload_last;
		logic [BYTE_W-1:0]   command;
		logic [BYTE_W-1:0]   seq_num;
		logic [BYTE_W-1:0]   length;
		logic [REASON_W-1:0] reason;
	} rec_t;

	// One byte of CRC-16/CCITT-FALSE, MSB first.
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic known_command(input logic [BYTE_W-1:0] c);
		logic ok;
		case (c) inside
			8'h01, 8'h02, 8'h10, 8'h11, 8'h20, 8'h21, 8'h22, 8'h30,
			8'h40, 8'h41, 8'h50, 8'h51, 8'hF0, 8'hF1, 8'hF2, 8'hFF: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

### sv/crcfd_parser.sv
module crcfd_parser (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                byte_valid,
	input  logic [crcfd_pkg::BYTE_W-1:0]        byte_in,
	input  logic                                cfg_we,
	input  logic [crcfd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [crcfd_pkg::BYTE_W-1:0]        cfg_data,
	output logic                                rec_valid,
	output crcfd_pkg::rec_t                     rec
);

	logic [crcfd_pkg::BYTE_W-1:0] sync_first_q, sync_second_q, end_marker_q, max_payload_q;

	crcfd_pkg::phase_t            phase_q, phase_d;
	logic [crcfd_pkg::BYTE_W-1:0] length_low_q, length_low_d;
	logic [crcfd_pkg::BYTE_W-1:0] payload_length_q, payload_length_d;
	logic [crcfd_pkg::BYTE_W-1:0] byte_count_q, byte_count_d;
	logic [crcfd_pkg::BYTE_W-1:0] command_q, command_d;
	logic [crcfd_pkg::BYTE_W-1:0] sequence_q, sequence_d;
	logic [crcfd_pkg::BYTE_W-1:0] crc_low_q, crc_low_d;
	logic [crcfd_pkg::CRC_W-1:0]  crc_q, crc_d;
	logic [crcfd_pkg::CRC_W-1:0]  crc_base, crc_next;
	logic [crcfd_pkg::BYTE_W-1:0] count_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= crcfd_pkg::SYNC_FIRST_RST;
			sync_second_q <= crcfd_pkg::SYNC_SECOND_RST;
			end_marker_q  <= crcfd_pkg::END_MARKER_RST;
			max_payload_q <= crcfd_pkg::MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				crcfd_pkg::REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				crcfd_pkg::REG_SYNC_SECOND: sync_second_q <= cfg_data;
				crcfd_pkg::REG_END_MARKER:  end_marker_q  <= cfg_data;
				crcfd_pkg::REG_MAX_PAYLOAD: max_payload_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= crcfd_pkg::PH_SYNC1;
			length_low_q     <= '0;
			payload_length_q <= '0;
			byte_count_q     <= '0;
			command_q        <= '0;
			sequence_q       <= '0;
			crc_low_q        <= '0;
			crc_q            <= crcfd_pkg::CRC_INIT;
		end else if (byte_valid) begin
			phase_q          <= phase_d;
			length_low_q     <= length_low_d;
			payload_length_q <= payload_length_d;
			byte_count_q     <= byte_count_d;
			command_q        <= command_d;
			sequence_q       <= sequence_d;
			crc_low_q        <= crc_low_d;
			crc_q            <= crc_d;
		end
	end

	// The command byte restarts the CRC; every later covered byte continues it.
	assign crc_base  = (phase_q == crcfd_pkg::PH_CMD) ? crcfd_pkg::CRC_INIT : crc_q;
	assign crc_next  = crcfd_pkg::crc_byte(crc_base, byte_in);
	assign count_inc = byte_count_q + 1'b1;

	always_comb begin
		phase_d          = phase_q;
		length_low_d     = length_low_q;
		payload_length_d = payload_length_q;
		byte_count_d     = byte_count_q;
		command_d        = command_q;
		sequence_d       = sequence_q;
		crc_low_d        = crc_low_q;
		crc_d            = crc_q;
		rec_valid        = 1'b0;
		rec              = '0;
		unique case (phase_q)
			crcfd_pkg::PH_SYNC2: begin
				if (byte_in == sync_second_q) begin
					phase_d = crcfd_pkg::PH_LEN_LO;
				end else if (byte_in != sync_first_q) begin
					phase_d          = crcfd_pkg::PH_SYNC1;
					length_low_d     = '0;
					payload_length_d = '0;
					byte_count_d     = '0;
				end
			end
			crcfd_pkg::PH_LEN_LO: begin
				length_low_d = byte_in;
				phase_d      = crcfd_pkg::PH_LEN_HI;
			end
			crcfd_pkg::PH_LEN_HI: begin
				if (byte_in != '0 || length_low_q > max_payload_q) begin
					rec_valid        = byte_valid;
					rec.kind         = crcfd_pkg::KIND_REJECT;
					rec.reason       = crcfd_pkg::WHY_LENGTH;
					rec.length       = (byte_in != '0) ? crcfd_pkg::LEN_SAT : length_low_q;
					phase_d          = crcfd_pkg::PH_SYNC1;
					length_low_d     = '0;
					payload_length_d = '0;
					byte_count_d     = '0;
				end else begin
					payload_length_d = length_low_q;
					phase_d          = crcfd_pkg::PH_CMD;
				end
			end
			crcfd_pkg::PH_CMD: begin
				command_d = byte_in;
				crc_d     = crc_next;
				phase_d   = crcfd_pkg::PH_SEQ;
			end
			crcfd_pkg::PH_SEQ: begin
				sequence_d   = byte_in;
				crc_d        = crc_next;
				byte_count_d = '0;
				phase_d      = (payload_length_q == '0) ? crcfd_pkg::PH_CRC_LO
				                                        : crcfd_pkg::PH_DATA;
			end
			crcfd_pkg::PH_DATA: begin
				crc_d             = crc_next;
				byte_count_d      = count_inc;
				rec_valid         = byte_valid;
				rec.kind          = crcfd_pkg::KIND_DATA;
				rec.payload_byte  = byte_in;
				rec.payload_last  = (count_inc >= payload_length_q);
				if (count_inc >= payload_length_q) begin
					phase_d = crcfd_pkg::PH_CRC_LO;
				end
			end
			crcfd_pkg::PH_CRC_LO: begin
				crc_low_d = byte_in;
				phase_d   = crcfd_pkg::PH_CRC_HI;
			end
			crcfd_pkg::PH_CRC_HI: begin
				if ({byte_in, crc_low_q} == crc_q) begin
					phase_d = crcfd_pkg::PH_END;
				end else begin
					rec_valid        = byte_valid;
					rec.kind         = crcfd_pkg::KIND_REJECT;
					rec.reason       = crcfd_pkg::WHY_CRC;
					rec.command      = command_q;
					rec.seq_num      = sequence_q;
					rec.length       = payload_length_q;
					phase_d          = crcfd_pkg::PH_SYNC1;
					length_low_d     = '0;
					payload_length_d = '0;
					byte_count_d     = '0;
				end
			end
			crcfd_pkg::PH_END: begin
				rec_valid    = byte_valid;
				rec.command  = command_q;
				rec.seq_num  = sequence_q;
				rec.length   = payload_length_q;
				if (byte_in != end_marker_q) begin
					rec.kind   = crcfd_pkg::KIND_REJECT;
					rec.reason = crcfd_pkg::WHY_END;
				end else if (!crcfd_pkg::known_command(command_q)) begin
					rec.kind   = crcfd_pkg::KIND_REJECT;
					rec.reason = crcfd_pkg::WHY_CMD;
				end else begin
					rec.kind   = crcfd_pkg::KIND_ACCEPT;
					rec.reason = crcfd_pkg::WHY_NONE;
				end
				phase_d          = crcfd_pkg::PH_SYNC1;
				length_low_d     = '0;
				payload_length_d = '0;
				byte_count_d     = '0;
			end
			default: begin
				phase_d = (byte_in == sync_first_q) ? crcfd_pkg::PH_SYNC2
				                                    : crcfd_pkg::PH_SYNC1;
			end
		endcase
	end

endmodule

### sv/crcfd_fifo.sv
module crcfd_fifo #(
	parameter int unsigned DEPTH = crcfd_pkg::FIFO_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  crcfd_pkg::rec_t wr_data,
	input  logic            rd_en,
	output crcfd_pkg::rec_t rd_data,
	output logic            not_empty,
	output logic            is_full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	crcfd_pkg::rec_t    mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr, do_rd;

	assign do_wr     = wr_en && !is_full;
	assign do_rd     = rd_en && not_empty;
	assign not_empty = (count_q != '0);
	assign is_full   = (count_q == CNT_W'(DEPTH));
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/crcfd_out.sv
module crcfd_out (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_not_empty,
	input  crcfd_pkg::rec_t q_data,
	output logic            q_pop,
	input  logic            pop,
	output logic            empty,
	output crcfd_pkg::rec_t out_rec
);

	logic            valid_q;
	crcfd_pkg::rec_t rec_q;

	// Refill the output register whenever it is free or its record is being transferred.
	assign q_pop   = q_not_empty && (!valid_q || pop);
	assign empty   = !valid_q;
	assign out_rec = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rec_q <= q_data;
		end
	end

endmodule

### sv/crc16_frame_deframer.sv
// Byte-stream frame parser: one received byte may be transferred every clock cycle,
// back to back, as long as full is low. The parser hunts for the two sync bytes, reads
// length, command, sequence, payload, CRC-16/CCITT-FALSE and end marker, and updates the
// CRC one byte per cycle while full is low. Each payload byte and each frame verdict
// becomes one result; results pass through a FIFO_DEPTH-entry queue and then an output
// register before they show on the result ports. full rises only when the queue holds
// FIFO_DEPTH results that the output side has not taken; with pop held high the block
// sustains one byte per cycle. Configuration writes take effect at the next byte and
// should be made only while no frame is in progress.
module crc16_frame_deframer #(
	parameter int unsigned FIFO_DEPTH = crcfd_pkg::FIFO_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [crcfd_pkg::BYTE_W-1:0]        in_byte,
	output logic                                empty,
	input  logic                                pop,
	output logic [crcfd_pkg::KIND_W-1:0]        result_kind,
	output logic [crcfd_pkg::BYTE_W-1:0]        payload_byte,
	output logic                                payload_last,
	output logic [crcfd_pkg::BYTE_W-1:0]        frame_command,
	output logic [crcfd_pkg::BYTE_W-1:0]        frame_sequence,
	output logic [crcfd_pkg::BYTE_W-1:0]        frame_length,
	output logic [crcfd_pkg::REASON_W-1:0]      reject_reason,
	input  logic                                cfg_we,
	input  logic [crcfd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [crcfd_pkg::BYTE_W-1:0]        cfg_data
);

	logic            accept;
	logic            rec_valid;
	crcfd_pkg::rec_t rec;
	crcfd_pkg::rec_t q_data;
	crcfd_pkg::rec_t out_rec;
	logic            q_not_empty, q_full, q_pop;

	assign accept = push && !q_full;
	assign full   = q_full;

	crcfd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (accept),
		.byte_in    (in_byte),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rec_valid  (rec_valid),
		.rec        (rec)
	);

	crcfd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (rec_valid),
		.wr_data   (rec),
		.rd_en     (q_pop),
		.rd_data   (q_data),
		.not_empty (q_not_empty),
		.is_full   (q_full)
	);

	crcfd_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.out_rec     (out_rec)
	);

	assign result_kind    = out_rec.kind;
	assign payload_byte   = out_rec.payload_byte;
	assign payload_last   = out_rec.payload_last;
	assign frame_command  = out_rec.command;
	assign frame_sequence = out_rec.seq_num;
	assign frame_length   = out_rec.length;
	assign reject_reason  = out_rec.reason;

endmodule

### sv/crcfd_checker.sv
module crcfd_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                push,
	input logic                                full,
	input logic [crcfd_pkg::BYTE_W-1:0]        in_byte,
	input logic                                empty,
	input logic                                pop,
	input logic [crcfd_pkg::KIND_W-1:0]        result_kind,
	input logic [crcfd_pkg::BYTE_W-1:0]        payload_byte,
	input logic                                payload_last,
	input logic [crcfd_pkg::BYTE_W-1:0]        frame_command,
	input logic [crcfd_pkg::BYTE_W-1:0]        frame_sequence,
	input logic [crcfd_pkg::BYTE_W-1:0]        frame_length,
	input logic [crcfd_pkg::REASON_W-1:0]      reject_reason,
	input logic                                cfg_we,
	input logic [crcfd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input logic [crcfd_pkg::BYTE_W-1:0]        cfg_data
);

	// A rejected frame always carries a reason, other results never do.
	a_reason_matches_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((result_kind == crcfd_pkg::KIND_REJECT) == (reject_reason != crcfd_pkg::WHY_NONE)))
		else $error("reject_reason does not match result_kind");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result_kind == crcfd_pkg::KIND_DATA || result_kind == crcfd_pkg::KIND_ACCEPT
		            || result_kind == crcfd_pkg::KIND_REJECT))
		else $error("unused result_kind code");

	a_last_only_on_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && payload_last) |-> (result_kind == crcfd_pkg::KIND_DATA))
		else $error("payload_last set on a verdict");

	// The queue can only fill up through an input transfer.
	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without an input transfer");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result_kind) && $stable(payload_byte)
		                      && $stable(reject_reason)))
		else $error("waiting result changed before its transfer");

endmodule

bind crc16_frame_deframer crcfd_checker u_crcfd_checker (.*);

### tb/sv/deframer_checker.sv
`timescale 1ns / 100ps

module deframer_checker
	import crcfd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  logic [BYTE_W-1:0]   in_byte,
	input  logic                empty,
	input  logic                pop,
	input  logic [KIND_W-1:0]   result_kind,
	input  logic [BYTE_W-1:0]   payload_byte,
	input  logic                payload_last,
	input  logic [BYTE_W-1:0]   frame_command,
	input  logic [BYTE_W-1:0]   frame_sequence,
	input  logic [BYTE_W-1:0]   frame_length,
	input  logic [REASON_W-1:0] reject_reason,
	input  logic                cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]   cfg_data,
	output int                  fail_count,
	output int                  results_waiting,
	output int                  data_count,
	output int                  accept_count,
	output int                  reject_count
);

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [BYTE_W-1:0]   data;
		logic                last;
		logic [BYTE_W-1:0]   cmd;
		logic [BYTE_W-1:0]   seq;
		logic [BYTE_W-1:0]   len;
		logic [REASON_W-1:0] why;
	} parse_result_t;

	parse_result_t expected_q[$];

	// Shadow copy of the register file.
	logic [BYTE_W-1:0] sync_a, sync_b, end_byte, len_limit;

	// Shadow copy of the parser state.
	phase_t            phase;
	logic [BYTE_W-1:0] len_lo, pay_len, count, cmd_q, seq_q, crc_lo;
	logic [CRC_W-1:0]  crc_acc;

	function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		repeat (8) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction

	function automatic logic command_known(input logic [BYTE_W-1:0] c);
		case (c)
			8'h01, 8'h02, 8'h10, 8'h11, 8'h20, 8'h21, 8'h22, 8'h30,
			8'h40, 8'h41, 8'h50, 8'h51, 8'hF0, 8'hF1, 8'hF2, 8'hFF: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic expect_result(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data,
		input logic last, input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] seq,
		input logic [BYTE_W-1:0] len, input logic [REASON_W-1:0] why);
		parse_result_t r;
		r = '{kind, data, last, cmd, seq, len, why};
		expected_q.push_back(r);
	endtask

	task automatic hunt_restart();
		phase   = PH_SYNC1;
		len_lo  = '0;
		pay_len = '0;
		count   = '0;
	endtask

	task automatic parse_byte(input logic [BYTE_W-1:0] b);
		logic [15:0]         len16;
		logic [REASON_W-1:0] why;
		case (phase)
			PH_SYNC2: begin
				// A repeated first sync byte keeps the hunt in this phase.
				if (b == sync_b) phase = PH_LEN_LO;
				else if (b != sync_a) hunt_restart();
			end
			PH_LEN_LO: begin
				len_lo = b;
				phase  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len16 = {b, len_lo};
				if (len16 > {8'h00, len_limit}) begin
					hunt_restart();
					expect_result(KIND_REJECT, '0, 1'b0, '0, '0,
						(len16 > 16'd255) ? LEN_SAT : len16[7:0], WHY_LENGTH);
				end else begin
					pay_len = len16[7:0];
					phase   = PH_CMD;
				end
			end
			PH_CMD: begin
				cmd_q   = b;
				crc_acc = crc_step(CRC_INIT, b);
				phase   = PH_SEQ;
			end
			PH_SEQ: begin
				seq_q   = b;
				crc_acc = crc_step(crc_acc, b);
				count   = '0;
				phase   = (pay_len == 0) ? PH_CRC_LO : PH_DATA;
			end
			PH_DATA: begin
				crc_acc = crc_step(crc_acc, b);
				count   = count + 8'd1;
				if (count >= pay_len) phase = PH_CRC_LO;
				expect_result(KIND_DATA, b, count >= pay_len, '0, '0, '0, WHY_NONE);
			end
			PH_CRC_LO: begin
				crc_lo = b;
				phase  = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				if ({b, crc_lo} == crc_acc) begin
					phase = PH_END;
				end else begin
					expect_result(KIND_REJECT, '0, 1'b0, cmd_q, seq_q, pay_len, WHY_CRC);
					hunt_restart();
				end
			end
			PH_END: begin
				// The end byte is judged before the command.
				if (b != end_byte) why = WHY_END;
				else if (!command_known(cmd_q)) why = WHY_CMD;
				else why = WHY_NONE;
				expect_result((why == WHY_NONE) ? KIND_ACCEPT : KIND_REJECT, '0, 1'b0,
					cmd_q, seq_q, pay_len, why);
				hunt_restart();
			end
			default: begin
				phase = (b == sync_a) ? PH_SYNC2 : PH_SYNC1;
			end
		endcase
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : watch
		parse_result_t want;
		if (!arst_n) begin
			sync_a    = SYNC_FIRST_RST;
			sync_b    = SYNC_SECOND_RST;
			end_byte  = END_MARKER_RST;
			len_limit = MAX_PAYLOAD_RST;
			hunt_restart();
			cmd_q     = '0;
			seq_q     = '0;
			crc_lo    = '0;
			crc_acc   = CRC_INIT;
			expected_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SYNC_FIRST:  sync_a    = cfg_data;
					REG_SYNC_SECOND: sync_b    = cfg_data;
					REG_END_MARKER:  end_byte  = cfg_data;
					REG_MAX_PAYLOAD: len_limit = cfg_data;
					default: ;
				endcase
			end
			if (push && !full) parse_byte(in_byte);
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					$error("result transfer with nothing expected: kind %0d", result_kind);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					check_field("result_kind", want.kind, result_kind);
					check_field("payload_byte", want.data, payload_byte);
					check_field("payload_last", want.last, payload_last);
					check_field("frame_command", want.cmd, frame_command);
					check_field("frame_sequence", want.seq, frame_sequence);
					check_field("frame_length", want.len, frame_length);
					check_field("reject_reason", want.why, reject_reason);
					case (want.kind)
						KIND_DATA:   data_count++;
						KIND_ACCEPT: accept_count++;
						default:     reject_count++;
					endcase
				end
			end
		end
		results_waiting <= expected_q.size();
	end

endmodule

### tb/sv/tb_crc16_frame_deframer.sv
`timescale 1ns / 100ps

module tb_crc16_frame_deframer;
	import crcfd_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int BYTE_BUDGET = 1550;
	localparam int NUM_PHASES  = 6;
	localparam logic [16*8-1:0] KNOWN_CMDS = {
		8'h01, 8'h02, 8'h10, 8'h11, 8'h20, 8'h21, 8'h22, 8'h30,
		8'h40, 8'h41, 8'h50, 8'h51, 8'hF0, 8'hF1, 8'hF2, 8'hFF
	};

	typedef enum int {
		FRAME_GOOD,
		FRAME_LONG,
		FRAME_BAD_CRC,
		FRAME_BAD_END,
		FRAME_ODD_CMD,
		FRAME_NOISE,
		FRAME_FALSE_SYNC
	} frame_style_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 push      = 1'b0;
	logic [BYTE_W-1:0]    in_byte   = '0;
	logic                 pop       = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_data  = '0;

	logic                 full, empty, payload_last;
	logic [KIND_W-1:0]    result_kind;
	logic [BYTE_W-1:0]    payload_byte, frame_command, frame_sequence, frame_length;
	logic [REASON_W-1:0]  reject_reason;

	int fail_count, results_waiting, data_count, accept_count, reject_count;

	// Frames are built against the settings last written.
	logic [BYTE_W-1:0] cur_sf = SYNC_FIRST_RST;
	logic [BYTE_W-1:0] cur_ss = SYNC_SECOND_RST;
	logic [BYTE_W-1:0] cur_em = END_MARKER_RST;
	logic [BYTE_W-1:0] cur_mp = MAX_PAYLOAD_RST;

	logic calm = 1'b0;
	int   bytes_sent = 0;
	int   frames_sent = 0;
	int   stall_cycles = 0;
	int   pop_hold = 0;

	crc16_frame_deframer i_dut (.*);

	deframer_checker i_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The consumer idles at random and now and then holds off long enough to fill the queue.
	always @(posedge clk) begin
		if (pop_hold > 0) begin
			pop_hold <= pop_hold - 1;
			pop      <= 1'b0;
		end else if (!calm && $urandom_range(199) == 0) begin
			pop_hold <= $urandom_range(20, 6);
			pop      <= 1'b0;
		end else begin
			pop <= calm || ($urandom_range(99) >= 33);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic [CRC_W-1:0] frame_crc_add(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction

	// Leaves push high after the transfer so that the next byte can follow back to back.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while (!calm && $urandom_range(99) < 33) begin
			push    <= 1'b0;
			in_byte <= 8'($urandom);
			@(posedge clk);
		end
		push    <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (results_waiting != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic load_config(input logic [BYTE_W-1:0] sf, input logic [BYTE_W-1:0] ss,
		input logic [BYTE_W-1:0] em, input logic [BYTE_W-1:0] mp);
		put_reg(REG_SYNC_FIRST, sf);
		put_reg(REG_SYNC_SECOND, ss);
		put_reg(REG_END_MARKER, em);
		put_reg(REG_MAX_PAYLOAD, mp);
		cfg_we <= 1'b0;
		cur_sf = sf;
		cur_ss = ss;
		cur_em = em;
		cur_mp = mp;
	endtask

	// A nonzero crc_flip corrupts the checksum; the end byte is then left out.
	task automatic emit_frame(input logic twice_sync, input logic [15:0] len16,
		input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] seq,
		input logic [CRC_W-1:0] crc_flip, input logic [BYTE_W-1:0] endb);
		logic [CRC_W-1:0]  crc;
		logic [BYTE_W-1:0] d;
		send_byte(cur_sf);
		if (twice_sync) send_byte(cur_sf);
		send_byte(cur_ss);
		send_byte(len16[7:0]);
		send_byte(len16[15:8]);
		frames_sent++;
		if (len16 > {8'h00, cur_mp}) return;
		crc = frame_crc_add(CRC_INIT, cmd);
		crc = frame_crc_add(crc, seq);
		send_byte(cmd);
		send_byte(seq);
		for (int i = 0; i < int'(len16); i++) begin
			d   = 8'($urandom);
			crc = frame_crc_add(crc, d);
			send_byte(d);
		end
		crc = crc ^ crc_flip;
		send_byte(crc[7:0]);
		send_byte(crc[15:8]);
		if (crc_flip != '0) return;
		send_byte(endb);
	endtask

	task automatic send_frame(input frame_style_t style);
		logic [15:0]       len16;
		logic [BYTE_W-1:0] cmd, pick, endb;
		int                cap;
		case (style)
			FRAME_NOISE: begin
				repeat ($urandom_range(6, 1)) begin
					pick = 8'($urandom);
					while (pick == cur_sf) pick = 8'($urandom);
					send_byte(pick);
				end
			end
			FRAME_FALSE_SYNC: begin
				send_byte(cur_sf);
				pick = 8'($urandom);
				while (pick == cur_sf || pick == cur_ss) pick = 8'($urandom);
				send_byte(pick);
			end
			default: begin
				if (style == FRAME_LONG) begin
					if (cur_mp == 8'hFF || $urandom_range(1) == 1)
						len16 = {8'($urandom_range(255, 1)), 8'($urandom)};
					else
						len16 = 16'($urandom_range(255, int'(cur_mp) + 1));
				end else begin
					// Mostly short payloads; an occasional one up to the limit.
					cap = ($urandom_range(49) == 0) ? int'(cur_mp) :
						((cur_mp < 12) ? int'(cur_mp) : 12);
					len16 = 16'($urandom_range(cap, 0));
				end
				if (style == FRAME_ODD_CMD) cmd = 8'($urandom);
				else cmd = KNOWN_CMDS[8*$urandom_range(15) +: 8];
				endb = cur_em;
				if (style == FRAME_BAD_END)
					while (endb == cur_em) endb = 8'($urandom);
				emit_frame(cur_sf != cur_ss && $urandom_range(3) == 0, len16, cmd,
					8'($urandom),
					(style == FRAME_BAD_CRC) ? 16'($urandom_range(65535, 1)) : 16'h0000,
					endb);
			end
		endcase
	endtask

	initial begin
		int           r;
		int           phase_end;
		frame_style_t style;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames under the reset settings: an empty payload after a repeated
		// first sync byte, a failed second sync, a length far over the limit and a
		// checksum mismatch.
		emit_frame(1'b1, 16'h0000, 8'h01, 8'hFF, 16'h0000, cur_em);
		send_byte(cur_sf);
		send_byte(8'h12);
		emit_frame(1'b0, 16'hFFFF, 8'h00, 8'h00, 16'h0000, cur_em);
		emit_frame(1'b0, 16'h0000, 8'h00, 8'h00, 16'h8000, cur_em);
		settle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: load_config(SYNC_FIRST_RST, SYNC_SECOND_RST, END_MARKER_RST,
					MAX_PAYLOAD_RST);
				1: load_config(8'h00, 8'hFF, 8'hFF, 8'h00);
				2: load_config(8'hFF, 8'h00, 8'h00, 8'hFF);
				3: load_config(8'h5A, 8'h5A, 8'h7E, 8'h08);
				4: load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				default: load_config(8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom_range(30)));
			endcase
			// The first phase runs without any idling on either side.
			calm <= (p == 0);
			phase_end = bytes_sent + BYTE_BUDGET / NUM_PHASES;
			while (bytes_sent < phase_end) begin
				r = $urandom_range(99);
				if (r < 55) style = FRAME_GOOD;
				else if (r < 63) style = FRAME_LONG;
				else if (r < 71) style = FRAME_BAD_CRC;
				else if (r < 79) style = FRAME_BAD_END;
				else if (r < 87) style = FRAME_ODD_CMD;
				else if (r < 94) style = FRAME_NOISE;
				else style = FRAME_FALSE_SYNC;
				send_frame(style);
			end
			settle();
		end

		$display("Streamed %0d bytes carrying %0d frames under %0d register settings.",
			bytes_sent, frames_sent, NUM_PHASES + 1);
		$display("Compared %0d payload bytes, %0d accepted and %0d rejected frames.",
			data_count, accept_count, reject_count);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### crc16_frame_deframer.f
sv/crcfd_pkg.sv
sv/crcfd_parser.sv
sv/crcfd_fifo.sv
sv/crcfd_out.sv
sv/crc16_frame_deframer.sv
sv/crcfd_checker.sv
tb/sv/deframer_checker.sv
tb/sv/tb_crc16_frame_deframer.sv
